[sv/first_fit_interval_allocator_defines.svh]
// Assertion macros used by the allocator's top-level RTL file.
// Depends on nothing; the including module must have clock and reset.
`ifndef FIRST_FIT_INTERVAL_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_INTERVAL_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFIA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFIA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[sv/ffia_pkg.sv]
// Shared types, codes and constants of the first-fit interval allocator.
// Depends on nothing; used by the top-level module and by ffia_cell.
`default_nettype none
package ffia_pkg;

   localparam int AddrBits       = 16;
   localparam int ReqNumBits     = 10;
   localparam int DefMaxRequests = 1024;
   localparam int DefMaxFreeRuns = 512;
   localparam int CsrAddrBits    = 2;
   localparam int CsrDataBits    = 32;

   localparam logic [AddrBits-1:0]    MemSizeReset   = 16'hFFFF;
   localparam logic [CsrAddrBits-1:0] CsrMemSizeAddr = 2'd0;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [1:0] MODE_ALLOC = 2'd0;
   localparam logic [1:0] MODE_FREE  = 2'd1;
   localparam logic [1:0] MODE_SHL   = 2'd2;
   localparam logic [1:0] MODE_SHR   = 2'd3;

   typedef struct packed {
      logic                  func;
      logic [AddrBits-1:0]   block_size;
      logic [ReqNumBits-1:0] request_number;
   } req_type;

   typedef struct packed {
      logic [AddrBits-1:0] start_address;
      logic                rejected;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic [AddrBits-1:0] first;
      logic [AddrBits-1:0] last;
   } run_type;

   typedef struct packed {
      logic                valid;
      logic [1:0]          mode;
      logic [AddrBits-1:0] a;
      logic [AddrBits-1:0] hi;
      logic [AddrBits-1:0] prev_last;
      logic                has_prev;
      logic [AddrBits-1:0] start;
      logic                inc;
      logic                dec;
   } tok_type;

   typedef struct packed {
      logic                valid;
      logic                fail;
      logic [AddrBits-1:0] start;
      logic                inc;
      logic                dec;
   } done_type;

   typedef struct packed {
      logic                valid;
      logic [AddrBits-1:0] last;
   } wr_type;

   typedef struct packed {
      logic                live;
      logic [AddrBits-1:0] first;
      logic [AddrBits-1:0] last;
   } grant_type;

endpackage
`default_nettype wire

[sv/first_fit_interval_allocator.sv]
// An allocation answers after a token has walked the chain of run cells once, one cell per
// cycle (search, then any shift); an allocation refused on entry skips the walk.
// The block takes one item at a time, and an allocation can be held by a stalled earlier
// response.
// Reset and each mem_size write rebuild the run list at once and then clear every entry of
// the grant table, during which no transfer is taken.
`default_nettype none
`include "first_fit_interval_allocator_defines.svh"
module first_fit_interval_allocator #(
   parameter int MAX_REQUESTS  = ffia_pkg::DefMaxRequests,
   parameter int MAX_FREE_RUNS = ffia_pkg::DefMaxFreeRuns
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire ffia_pkg::req_type                    req_payload,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   output      ffia_pkg::rsp_type                    rsp_payload,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [ffia_pkg::CsrAddrBits-1:0]     csr_paddr,
   input  wire logic [ffia_pkg::CsrDataBits-1:0]     csr_pwdata,
   output      logic [ffia_pkg::CsrDataBits-1:0]     csr_prdata,
   output      logic                                 csr_pready
);

   localparam int IdxW  = $clog2(MAX_REQUESTS);
   localparam int SeqW  = IdxW + 1;
   localparam int CntW  = $clog2(MAX_FREE_RUNS + 1);
   localparam int NCell = MAX_FREE_RUNS + 1;
   localparam int RnExt = IdxW + ffia_pkg::ReqNumBits;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_RUN   = 3'd3;
   localparam logic [2:0] ST_POST  = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [ffia_pkg::AddrBits-1:0] mem_ff, mem_in;
   logic [CntW-1:0]               cnt_ff, cnt_in;
   logic [SeqW-1:0]               seq_ff, seq_in, seq_nx;
   logic [IdxW-1:0]               clr_ff, clr_in;
   ffia_pkg::tok_type             launch_ff, launch_in;
   logic                          func_ff, func_in;
   logic [ffia_pkg::AddrBits-1:0] size_ff, size_in;
   logic [IdxW-1:0]               rn_ff, rn_in;
   logic                          fail_ff, fail_in;
   logic [ffia_pkg::AddrBits-1:0] start_ff, start_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   ffia_pkg::rsp_type             rsp_ff, rsp_in;

   logic                          accept, cfg_wr, cell_init, full;
   logic [RnExt-1:0]              rn_ext;
   logic [ffia_pkg::AddrBits-1:0] init_size;
   ffia_pkg::run_type             init_run0;
   ffia_pkg::done_type            done_any;
   logic [NCell-1:0]              done_vec;

   logic                          ram_wr_en;
   logic [IdxW-1:0]               ram_wr_addr;
   ffia_pkg::grant_type           ram_wr_data, ram_rd_data;

   ffia_pkg::run_type  run_a  [NCell];
   ffia_pkg::tok_type  tok_a  [NCell+1];
   ffia_pkg::wr_type   wr_a   [NCell];
   ffia_pkg::done_type done_a [NCell];

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign cfg_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready
                      && (csr_paddr == ffia_pkg::CsrMemSizeAddr);
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(ffia_pkg::CsrDataBits-ffia_pkg::AddrBits){1'b0}}, mem_ff};
   assign rn_ext    = RnExt'(req_payload.request_number);
   assign full      = cnt_ff >= CntW'(MAX_FREE_RUNS);

   assign cell_init = reset || cfg_wr;
   assign init_size = reset ? ffia_pkg::MemSizeReset : csr_pwdata[ffia_pkg::AddrBits-1:0];
   always_comb begin
      init_run0.valid = init_size != '0;
      init_run0.first = 16'd1;
      init_run0.last  = init_size;
   end

   assign tok_a[0] = launch_ff;

   for (genvar k = 0; k < NCell; k++) begin : g_cell
      ffia_pkg::run_type nrun;
      ffia_pkg::wr_type  nwr;
      if (k == NCell - 1) begin : g_end
         assign nrun = '0;
         assign nwr  = '0;
      end else begin : g_mid
         assign nrun = run_a[k+1];
         assign nwr  = wr_a[k+1];
      end
      ffia_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .init     (cell_init),
         .init_run ((k == 0) ? init_run0 : '0),
         .full     (full),
         .tok_in   (tok_a[k]),
         .tok_out  (tok_a[k+1]),
         .next_run (nrun),
         .run_out  (run_a[k]),
         .next_wr  (nwr),
         .prev_wr  (wr_a[k]),
         .done_out (done_a[k])
      );
      assign done_vec[k] = done_a[k].valid;
   end

   always_comb begin
      done_any = '0;
      for (int k = 0; k < NCell; k++) begin
         done_any = done_any | done_a[k];
      end
   end

   ffia_ram #(
      .Width ($bits(ffia_pkg::grant_type)),
      .Depth (MAX_REQUESTS)
   ) u_grant_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (rn_ext[IdxW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      mem_in       = mem_ff;
      cnt_in       = cnt_ff;
      seq_in       = seq_ff;
      clr_in       = clr_ff;
      launch_in    = '0;
      func_in      = func_ff;
      size_in      = size_ff;
      rn_in        = rn_ff;
      fail_in      = fail_ff;
      start_in     = start_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = clr_ff;
      ram_wr_data  = '0;
      seq_nx       = (seq_ff < SeqW'(MAX_REQUESTS)) ? seq_ff + SeqW'(1) : seq_ff;
      if (cfg_wr) begin
         mem_in   = csr_pwdata[ffia_pkg::AddrBits-1:0];
         cnt_in   = CntW'(csr_pwdata[ffia_pkg::AddrBits-1:0] != '0);
         seq_in   = '0;
         clr_in   = '0;
         state_in = ST_CLEAR;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = clr_ff;
               if (clr_ff == IdxW'(MAX_REQUESTS - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  clr_in = clr_ff + IdxW'(1);
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  seq_in  = seq_nx;
                  func_in = req_payload.func;
                  size_in = req_payload.block_size;
                  rn_in   = rn_ext[IdxW-1:0];
                  if (req_payload.func == ffia_pkg::FUNC_ALLOC) begin
                     if (req_payload.block_size == '0 || seq_nx >= SeqW'(MAX_REQUESTS)
                         || full) begin
                        fail_in  = 1'b1;
                        start_in = '0;
                        state_in = ST_POST;
                     end else begin
                        launch_in.valid = 1'b1;
                        launch_in.mode  = ffia_pkg::MODE_ALLOC;
                        launch_in.a     = req_payload.block_size;
                        state_in        = ST_RUN;
                     end
                  end else if (32'(req_payload.request_number) < 32'(MAX_REQUESTS)) begin
                     state_in = ST_READ;
                  end
               end
            end
            ST_READ: begin
               if (ram_rd_data.live) begin
                  launch_in.valid = 1'b1;
                  launch_in.mode  = ffia_pkg::MODE_FREE;
                  launch_in.a     = ram_rd_data.first;
                  launch_in.hi    = ram_rd_data.last;
                  state_in        = ST_RUN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
            ST_RUN: begin
               if (done_any.valid) begin
                  cnt_in   = cnt_ff + CntW'(done_any.inc) - CntW'(done_any.dec);
                  fail_in  = done_any.fail;
                  start_in = done_any.start;
                  state_in = ST_POST;
               end
            end
            ST_POST: begin
               if (func_ff == ffia_pkg::FUNC_FREE) begin
                  ram_wr_en   = !fail_ff;
                  ram_wr_addr = rn_ff;
                  state_in    = ST_IDLE;
               end else if (!(rsp_valid_ff && rsp_stall)) begin
                  rsp_valid_in         = 1'b1;
                  rsp_in.start_address = fail_ff ? '0 : start_ff;
                  rsp_in.rejected      = fail_ff;
                  ram_wr_en            = !fail_ff;
                  ram_wr_addr          = seq_ff[IdxW-1:0];
                  ram_wr_data.live     = 1'b1;
                  ram_wr_data.first    = start_ff;
                  ram_wr_data.last     = start_ff + size_ff - 16'd1;
                  state_in             = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         mem_ff       <= ffia_pkg::MemSizeReset;
         cnt_ff       <= CntW'(1);
         seq_ff       <= '0;
         clr_ff       <= '0;
         launch_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mem_ff       <= mem_in;
         cnt_ff       <= cnt_in;
         seq_ff       <= seq_in;
         clr_ff       <= clr_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff  <= func_in;
      size_ff  <= size_in;
      rn_ff    <= rn_in;
      fail_ff  <= fail_in;
      start_ff <= start_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `FFIA_ASSERT_NOW(a_done_in_run, done_any.valid, state_ff == ST_RUN, "completion outside a run")
   `FFIA_ASSERT_NOW(a_one_done, 1'b1, $onehot0(done_vec), "several cells completed at once")
   `FFIA_ASSERT_NEXT(a_launch_run, launch_ff.valid && !cfg_wr, state_ff == ST_RUN || done_any.valid || state_ff == ST_POST, "token launched without a run")
   `FFIA_ASSERT_NOW(a_cnt_range, 1'b1, cnt_ff <= CntW'(MAX_FREE_RUNS), "run count overflow")

endmodule
`default_nettype wire

[sv/ffia_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none
module ffia_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output      logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[sv/ffia_cell.sv]
// One cell of the free-run chain: holds one free run and acts on the passing token.
// Depends on ffia_pkg.
`default_nettype none
module ffia_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               init,
   input  wire ffia_pkg::run_type  init_run,
   input  wire logic               full,
   input  wire ffia_pkg::tok_type  tok_in,
   output      ffia_pkg::tok_type  tok_out,
   input  wire ffia_pkg::run_type  next_run,
   output      ffia_pkg::run_type  run_out,
   input  wire ffia_pkg::wr_type   next_wr,
   output      ffia_pkg::wr_type   prev_wr,
   output      ffia_pkg::done_type done_out
);

   ffia_pkg::run_type  run_ff, run_in;
   ffia_pkg::tok_type  tok_ff, tok_in_n;
   ffia_pkg::done_type done_ff, done_in;
   ffia_pkg::wr_type   pwr;

   logic [ffia_pkg::AddrBits:0]   len;
   logic [ffia_pkg::AddrBits-1:0] hi_a;
   logic                          jp, jn;

   always_comb begin
      run_in   = run_ff;
      tok_in_n = tok_in;
      tok_in_n.valid = 1'b0;
      done_in  = '0;
      pwr      = '0;
      len  = {1'b0, run_ff.last} - {1'b0, run_ff.first} + 17'd1;
      hi_a = run_ff.first + tok_in.a - 16'd1;
      jp   = tok_in.has_prev && ({1'b0, tok_in.prev_last} + 17'd1 == {1'b0, tok_in.a});
      jn   = run_ff.valid && ({1'b0, tok_in.hi} + 17'd1 == {1'b0, run_ff.first});
      if (init) begin
         run_in = init_run;
      end else if (tok_in.valid) begin
         done_in.start = tok_in.start;
         done_in.inc   = tok_in.inc;
         done_in.dec   = tok_in.dec;
         unique case (tok_in.mode)
            ffia_pkg::MODE_ALLOC: begin
               if (!run_ff.valid) begin
                  done_in.valid = 1'b1;
                  done_in.fail  = 1'b1;
               end else if (len >= {1'b0, tok_in.a}) begin
                  done_in.start  = run_ff.first;
                  tok_in_n.start = run_ff.first;
                  if (run_ff.last != hi_a) begin
                     run_in.first  = hi_a + 16'd1;
                     done_in.valid = 1'b1;
                  end else begin
                     run_in        = next_run;
                     done_in.dec   = 1'b1;
                     tok_in_n.dec  = 1'b1;
                     tok_in_n.mode = ffia_pkg::MODE_SHL;
                     tok_in_n.valid = next_run.valid;
                     done_in.valid  = !next_run.valid;
                  end
               end else begin
                  tok_in_n.valid = 1'b1;
               end
            end
            ffia_pkg::MODE_SHL: begin
               run_in         = next_run;
               tok_in_n.valid = next_run.valid;
               done_in.valid  = !next_run.valid;
            end
            ffia_pkg::MODE_FREE: begin
               if (run_ff.valid && run_ff.first <= tok_in.hi) begin
                  tok_in_n.valid     = 1'b1;
                  tok_in_n.prev_last = run_ff.last;
                  tok_in_n.has_prev  = 1'b1;
               end else if (jp && jn) begin
                  pwr.valid      = 1'b1;
                  pwr.last       = run_ff.last;
                  run_in         = next_run;
                  done_in.dec    = 1'b1;
                  tok_in_n.dec   = 1'b1;
                  tok_in_n.mode  = ffia_pkg::MODE_SHL;
                  tok_in_n.valid = next_run.valid;
                  done_in.valid  = !next_run.valid;
               end else if (jp) begin
                  pwr.valid     = 1'b1;
                  pwr.last      = tok_in.hi;
                  done_in.valid = 1'b1;
               end else if (jn) begin
                  run_in.first  = tok_in.a;
                  done_in.valid = 1'b1;
               end else if (full) begin
                  done_in.valid = 1'b1;
                  done_in.fail  = 1'b1;
               end else begin
                  run_in.valid   = 1'b1;
                  run_in.first   = tok_in.a;
                  run_in.last    = tok_in.hi;
                  done_in.inc    = 1'b1;
                  tok_in_n.inc   = 1'b1;
                  tok_in_n.mode  = ffia_pkg::MODE_SHR;
                  tok_in_n.a     = run_ff.first;
                  tok_in_n.hi    = run_ff.last;
                  tok_in_n.valid = run_ff.valid;
                  done_in.valid  = !run_ff.valid;
               end
            end
            ffia_pkg::MODE_SHR: begin
               run_in.valid   = 1'b1;
               run_in.first   = tok_in.a;
               run_in.last    = tok_in.hi;
               tok_in_n.a     = run_ff.first;
               tok_in_n.hi    = run_ff.last;
               tok_in_n.valid = run_ff.valid;
               done_in.valid  = !run_ff.valid;
            end
            default: begin
               done_in.valid = 1'b0;
            end
         endcase
      end else if (next_wr.valid) begin
         run_in.last = next_wr.last;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
      if (reset || init) begin
         tok_ff  <= '0;
         done_ff <= '0;
      end else begin
         tok_ff  <= tok_in_n;
         done_ff <= done_in;
      end
   end

   assign tok_out  = tok_ff;
   assign run_out  = run_ff;
   assign prev_wr  = pwr;
   assign done_out = done_ff;

endmodule
`default_nettype wire
